>>> hdl/mrsp_pkg.sv
// Shared types and constants for the MIDI running status byte parser.
package mrsp_pkg;

  typedef enum logic [3:0] {
    KIND_NOTE_ON    = 4'd0,
    KIND_NOTE_OFF   = 4'd1,
    KIND_CONTROL    = 4'd2,
    KIND_PITCH      = 4'd3,
    KIND_PROGRAM    = 4'd4,
    KIND_POLY_TOUCH = 4'd5,
    KIND_CHAN_TOUCH = 4'd6,
    KIND_REALTIME   = 4'd7,
    KIND_SX_START   = 4'd8,
    KIND_SX_DATA    = 4'd9,
    KIND_SX_STOP    = 4'd10
  } kind_t;

  // Status bytes with a meaning of their own
  localparam logic [7:0] STATUS_NONE     = 8'h00;
  localparam logic [7:0] STATUS_SX_START = 8'hF0;
  localparam logic [7:0] STATUS_SONG_POS = 8'hF2;
  localparam logic [7:0] STATUS_SONG_SEL = 8'hF3;
  localparam logic [7:0] STATUS_SX_STOP  = 8'hF7;
  localparam logic [7:0] REALTIME_MIN    = 8'hF8;

  // Upper nibbles of channel voice status bytes
  localparam logic [3:0] NIB_NOTE_OFF   = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON    = 4'h9;
  localparam logic [3:0] NIB_POLY_TOUCH = 4'hA;
  localparam logic [3:0] NIB_CONTROL    = 4'hB;
  localparam logic [3:0] NIB_PROGRAM    = 4'hC;
  localparam logic [3:0] NIB_CHAN_TOUCH = 4'hD;
  localparam logic [3:0] NIB_PITCH      = 4'hE;
  localparam logic [3:0] NIB_SYSTEM     = 4'hF;

  // Classified event as it travels through the queue. For a real-time
  // event, first_data carries the low seven bits of the real-time byte.
  typedef struct packed {
    kind_t      kind;
    logic [3:0] channel;
    logic [6:0] first_data;
    logic [6:0] second_data;
  } event_t;

  // Parser state kept by the front end
  typedef struct packed {
    logic [7:0] current_status;
    logic       awaiting_second;
    logic [6:0] held_first_data;
    logic       inside_sysex;
  } state_t;

  // Queue occupancy as seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

>>> hdl/midi_running_status_byte_parser.sv
// Top level of the MIDI 1.0 running status byte parser.
//
// Takes one received MIDI byte per transfer on the rx channel and gives decoded
// events on the event channel: channel voice messages (note-on at velocity zero
// comes out as note-off; program change and channel aftertouch come out on their
// single data byte), real-time bytes at once with no effect on the parser state,
// and SysEx start, data and stop. Any status byte but a real-time one ends
// SysEx; system common messages and their data are swallowed and clear the
// running status. A byte is taken every clock cycle while rx_stall is low;
// its event, if any, goes into the queue at the byte transfer and then into the
// output register once that register is free. The front end decodes a byte
// combinationally against its state registers; a queue of QUEUE_DEPTH entries
// and the output register sit behind it, so rx_stall rises only when the queue
// is full, which happens only while event_stall holds the output back.
module midi_running_status_byte_parser
  import mrsp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2  // event queue entries, 2 or more
)
(
  input  logic       clk,
  input  logic       rst,
  // received byte channel
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  // decoded event channel
  output logic       event_valid,
  input  logic       event_stall,
  output logic [3:0] event_kind,
  output logic [3:0] channel,
  output logic [6:0] first_data,
  output logic [6:0] second_data,
  output logic [7:0] realtime_code
);

  logic        rx_accept;
  logic        push;
  event_t      push_item;
  logic        pop;
  event_t      pop_item;
  queue_stat_t q_stat;
  state_t      parse_state;

  // Hold the byte off only when the queue has no room
  assign rx_stall  = q_stat.full;
  assign rx_accept = rx_valid && !rx_stall;

  // Decode the byte and advance the running status
  mrsp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx_byte),
    .accept    (rx_accept),
    .push      (push),
    .push_item (push_item),
    .state     (parse_state)
  );

  mrsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  // Drain the queue into the event register
  mrsp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .stat          (q_stat),
    .pop_item      (pop_item),
    .pop           (pop),
    .event_valid   (event_valid),
    .event_stall   (event_stall),
    .event_kind    (event_kind),
    .channel       (channel),
    .first_data    (first_data),
    .second_data   (second_data),
    .realtime_code (realtime_code)
  );

  // A real-time byte leaves the parser state untouched
  assert property (@(posedge clk) disable iff (rst)
    rx_accept && (rx_byte >= REALTIME_MIN) |=> parse_state == $past(parse_state))
    else $error("real-time byte changed parser state");

  // SysEx mode only ever follows a SysEx start status
  assert property (@(posedge clk) disable iff (rst)
    parse_state.inside_sysex |-> parse_state.current_status == STATUS_SX_START)
    else $error("inside SysEx without SysEx start status");

  // A real-time event carries its byte and no channel or data
  assert property (@(posedge clk) disable iff (rst)
    event_valid && (event_kind == KIND_REALTIME) |->
      realtime_code[7] && (channel == 4'd0) && (first_data == 7'd0) &&
      (second_data == 7'd0))
    else $error("malformed real-time event");

  // Only real-time events carry a real-time code
  assert property (@(posedge clk) disable iff (rst)
    event_valid && (event_kind != KIND_REALTIME) |-> realtime_code == 8'd0)
    else $error("real-time code on a non real-time event");

endmodule

>>> hdl/mrsp_front.sv
// Front end: holds the running status state and classifies each received byte.
module mrsp_front
  import mrsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  logic       accept,
  output logic       push,
  output event_t     push_item,
  output state_t     state
);

  state_t state_next;
  logic   emit;
  event_t ev;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    ev         = '0;
    if (rx_byte >= REALTIME_MIN) begin
      // real-time: pass through, touch nothing
      emit          = 1'b1;
      ev.kind       = KIND_REALTIME;
      ev.first_data = rx_byte[6:0];
    end else if (rx_byte[7]) begin
      state_next.current_status  = rx_byte;
      state_next.awaiting_second = 1'b0;
      state_next.inside_sysex    = (rx_byte == STATUS_SX_START);
      if (rx_byte == STATUS_SX_START) begin
        emit    = 1'b1;
        ev.kind = KIND_SX_START;
      end else if (rx_byte == STATUS_SX_STOP) begin
        emit    = 1'b1;
        ev.kind = KIND_SX_STOP;
      end
    end else if (state.inside_sysex) begin
      emit          = 1'b1;
      ev.kind       = KIND_SX_DATA;
      ev.first_data = rx_byte[6:0];
    end else if (state.awaiting_second) begin
      state_next.awaiting_second = 1'b0;
      ev.channel     = state.current_status[3:0];
      ev.first_data  = state.held_first_data;
      ev.second_data = rx_byte[6:0];
      case (state.current_status[7:4])
        NIB_NOTE_ON: begin
          emit    = 1'b1;
          ev.kind = (rx_byte[6:0] == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
        end
        NIB_NOTE_OFF: begin
          emit    = 1'b1;
          ev.kind = KIND_NOTE_OFF;
        end
        NIB_POLY_TOUCH: begin
          emit    = 1'b1;
          ev.kind = KIND_POLY_TOUCH;
        end
        NIB_CONTROL: begin
          emit    = 1'b1;
          ev.kind = KIND_CONTROL;
        end
        NIB_PITCH: begin
          emit    = 1'b1;
          ev.kind = KIND_PITCH;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end else begin
      case (state.current_status[7:4])
        NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_TOUCH, NIB_CONTROL, NIB_PITCH: begin
          state_next.awaiting_second = 1'b1;
          state_next.held_first_data = rx_byte[6:0];
        end
        NIB_PROGRAM, NIB_CHAN_TOUCH: begin
          state_next.held_first_data = rx_byte[6:0];
          emit          = 1'b1;
          ev.kind       = (state.current_status[7:4] == NIB_PROGRAM) ?
                          KIND_PROGRAM : KIND_CHAN_TOUCH;
          ev.channel    = state.current_status[3:0];
          ev.first_data = rx_byte[6:0];
        end
        NIB_SYSTEM: begin
          // system common data: swallow, drop running status
          state_next.current_status = STATUS_NONE;
          if (state.current_status == STATUS_SONG_POS) begin
            state_next.awaiting_second = 1'b1;
            state_next.held_first_data = rx_byte[6:0];
          end else if (state.current_status == STATUS_SONG_SEL) begin
            state_next.held_first_data = rx_byte[6:0];
          end
        end
        default: begin
          // no running status: ignore data
          emit = 1'b0;
        end
      endcase
    end
  end

  assign push      = accept && emit;
  assign push_item = ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/mrsp_queue.sv
// Short event queue between the front end and the back end.
module mrsp_queue
  import mrsp_pkg::*;
#(
  parameter int DEPTH = 2
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  event_t      push_item,
  input  logic        pop,
  output event_t      pop_item,
  output queue_stat_t stat
);

  localparam int IdxW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);

  event_t          entries [DEPTH];
  logic [IdxW-1:0] wr_ptr;
  logic [IdxW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign stat.full  = (count == CntW'(DEPTH));
  assign stat.empty = (count == '0);
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastIdx) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastIdx) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/mrsp_back.sv
// Back end: takes queued events and presents them on the event port register.
module mrsp_back
  import mrsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  queue_stat_t stat,
  input  event_t      pop_item,
  output logic        pop,
  output logic        event_valid,
  input  logic        event_stall,
  output logic [3:0]  event_kind,
  output logic [3:0]  channel,
  output logic [6:0]  first_data,
  output logic [6:0]  second_data,
  output logic [7:0]  realtime_code
);

  logic is_realtime;

  assign pop         = !stat.empty && (!event_valid || !event_stall);
  assign is_realtime = (pop_item.kind == KIND_REALTIME);

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (pop) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  // Expand the compact queue entry into the port fields
  always_ff @(posedge clk) begin
    if (pop) begin
      event_kind    <= pop_item.kind;
      channel       <= pop_item.channel;
      second_data   <= pop_item.second_data;
      first_data    <= is_realtime ? 7'd0 : pop_item.first_data;
      realtime_code <= is_realtime ? {1'b1, pop_item.first_data} : 8'd0;
    end
  end

endmodule

>>> test/tb.sv
// Self-checking bench for the MIDI running status byte parser: byte stream in, events checked.
module tb;
  import mrsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Value bounds used when building byte streams
  localparam logic [7:0] BYTE_MAX = 8'hFF;
  localparam logic [7:0] DATA_MAX = 8'h7F;

  // Stream length, calm window (no idling on either side) and the long
  // receiver hold-off that backs the parser up into its input
  localparam int RANDOM_BYTES = 1800;
  localparam int CALM_START   = 700;
  localparam int CALM_END     = 1100;
  localparam int HOLD_START   = 300;
  localparam int HOLD_LEN     = 80;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int SETTLE       = 16;

  // One decoded event as it should leave the parser
  typedef struct {
    kind_t      kind;
    logic [3:0] chan;
    logic [6:0] data1;
    logic [6:0] data2;
    logic [7:0] rt_code;
  } midi_event_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       event_valid;
  logic       event_stall = 1'b0;
  logic [3:0] event_kind;
  logic [3:0] channel;
  logic [6:0] first_data;
  logic [6:0] second_data;
  logic [7:0] realtime_code;

  // Bytes still to be offered, and events owed by bytes already taken
  logic [7:0]  bytes_to_send[$];
  midi_event_t events_due[$];

  // Shadow copy of the parser state
  logic [7:0] run_status = STATUS_NONE;
  logic       second_pending = 1'b0;
  logic [6:0] held_data = 7'd0;
  logic       sysex_open = 1'b0;

  bit rx_taken = 1'b0;
  int cyc = 0;
  int errors = 0;
  int recv_cycles = 0;
  int hold_left = 0;

  wire calm = (cyc >= CALM_START) && (cyc < CALM_END);

  midi_running_status_byte_parser dut (
    .clk           (clk),
    .rst           (rst),
    .rx_valid      (rx_valid),
    .rx_stall      (rx_stall),
    .rx_byte       (rx_byte),
    .event_valid   (event_valid),
    .event_stall   (event_stall),
    .event_kind    (event_kind),
    .channel       (channel),
    .first_data    (first_data),
    .second_data   (second_data),
    .realtime_code (realtime_code)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic midi_event_t make_event(kind_t k, logic [3:0] ch, logic [6:0] d1,
                                             logic [6:0] d2, logic [7:0] rt);
    midi_event_t ev;
    ev.kind    = k;
    ev.chan    = ch;
    ev.data1   = d1;
    ev.data2   = d2;
    ev.rt_code = rt;
    return ev;
  endfunction

  // Advance the shadow parser by one byte; report the event it causes, if any
  task automatic decode_rx_byte(input logic [7:0] b, output bit emits,
                                output midi_event_t ev);
    logic [3:0] ch;
    ch    = run_status[3:0];
    emits = 1'b0;
    ev    = make_event(KIND_NOTE_ON, 4'd0, 7'd0, 7'd0, 8'd0);
    if (b >= REALTIME_MIN) begin
      // real-time passes straight through, state untouched
      emits = 1'b1;
      ev    = make_event(KIND_REALTIME, 4'd0, 7'd0, 7'd0, b);
    end else if (b[7]) begin
      // any other status ends SysEx and replaces the running status
      sysex_open     = (b == STATUS_SX_START);
      run_status     = b;
      second_pending = 1'b0;
      if (b == STATUS_SX_START) begin
        emits = 1'b1;
        ev    = make_event(KIND_SX_START, 4'd0, 7'd0, 7'd0, 8'd0);
      end else if (b == STATUS_SX_STOP) begin
        emits = 1'b1;
        ev    = make_event(KIND_SX_STOP, 4'd0, 7'd0, 7'd0, 8'd0);
      end
    end else if (sysex_open) begin
      emits = 1'b1;
      ev    = make_event(KIND_SX_DATA, 4'd0, b[6:0], 7'd0, 8'd0);
    end else if (second_pending) begin
      second_pending = 1'b0;
      emits          = 1'b1;
      case (run_status[7:4])
        NIB_NOTE_ON: begin
          // velocity zero means note-off
          ev = make_event(b[6:0] == 7'd0 ? KIND_NOTE_OFF : KIND_NOTE_ON, ch, held_data,
                          b[6:0], 8'd0);
        end
        NIB_NOTE_OFF:   ev = make_event(KIND_NOTE_OFF, ch, held_data, b[6:0], 8'd0);
        NIB_POLY_TOUCH: ev = make_event(KIND_POLY_TOUCH, ch, held_data, b[6:0], 8'd0);
        NIB_CONTROL:    ev = make_event(KIND_CONTROL, ch, held_data, b[6:0], 8'd0);
        NIB_PITCH:      ev = make_event(KIND_PITCH, ch, held_data, b[6:0], 8'd0);
        default:        emits = 1'b0;  // second byte of song position
      endcase
    end else if (run_status != STATUS_NONE) begin
      case (run_status[7:4])
        NIB_PROGRAM, NIB_CHAN_TOUCH: begin
          held_data = b[6:0];
          emits     = 1'b1;
          ev        = make_event(run_status[7:4] == NIB_PROGRAM ? KIND_PROGRAM :
                                 KIND_CHAN_TOUCH, ch, b[6:0], 7'd0, 8'd0);
        end
        NIB_SYSTEM: begin
          // system common data is swallowed and drops the running status
          if (run_status == STATUS_SONG_POS) begin
            second_pending = 1'b1;
            held_data      = b[6:0];
          end else if (run_status == STATUS_SONG_SEL) begin
            held_data = b[6:0];
          end
          run_status = STATUS_NONE;
        end
        default: begin
          second_pending = 1'b1;
          held_data      = b[6:0];
        end
      endcase
    end
  endtask

  function automatic logic [7:0] pick_data();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return DATA_MAX;
      default: return 8'($urandom_range(DATA_MAX));
    endcase
  endfunction

  task automatic send(input logic [7:0] b);
    bytes_to_send.push_back(b);
  endtask

  // Queue a byte, now and then with a real-time byte slipped in ahead of it
  task automatic send_live(input logic [7:0] b);
    if ($urandom_range(99) < 5)
      bytes_to_send.push_back(8'($urandom_range(REALTIME_MIN, BYTE_MAX)));
    bytes_to_send.push_back(b);
  endtask

  // Sender: offer the next byte at the falling edge; hold it while stalled
  always @(negedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else if (!rx_valid || rx_taken) begin
      if (bytes_to_send.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
        rx_valid <= 1'b1;
        rx_byte  <= bytes_to_send.pop_front();
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off, and a calm window
  always @(negedge clk) begin
    if (rst) begin
      event_stall <= 1'b0;
    end else begin
      recv_cycles++;
      if (recv_cycles == HOLD_START)
        hold_left = HOLD_LEN;
      if (hold_left != 0) begin
        hold_left--;
        event_stall <= 1'b1;
      end else if (calm) begin
        event_stall <= 1'b0;
      end else begin
        event_stall <= ($urandom_range(99) < 20);
      end
    end
  end

  // Monitor: predict on each byte transfer, check each event transfer
  always @(posedge clk) begin : monitor
    bit          emits;
    midi_event_t ev;
    midi_event_t want;
    rx_taken = 1'b0;
    if (!rst) begin
      cyc++;
      rx_taken = rx_valid && !rx_stall;
      if (rx_taken) begin
        decode_rx_byte(rx_byte, emits, ev);
        if (emits)
          events_due.push_back(ev);
      end
      if (event_valid && !event_stall) begin
        if (events_due.size() == 0) begin
          $error("unexpected event: kind %0d channel %0d data %0d %0d realtime %0h",
                 event_kind, channel, first_data, second_data, realtime_code);
          errors++;
        end else begin
          want = events_due.pop_front();
          if (event_kind !== want.kind) begin
            $error("event_kind: expected %0d, actual %0d", want.kind, event_kind);
            errors++;
          end
          if (channel !== want.chan) begin
            $error("channel: expected %0d, actual %0d", want.chan, channel);
            errors++;
          end
          if (first_data !== want.data1) begin
            $error("first_data: expected %0d, actual %0d", want.data1, first_data);
            errors++;
          end
          if (second_data !== want.data2) begin
            $error("second_data: expected %0d, actual %0d", want.data2, second_data);
            errors++;
          end
          if (realtime_code !== want.rt_code) begin
            $error("realtime_code: expected %0h, actual %0h", want.rt_code, realtime_code);
            errors++;
          end
        end
      end
    end
  end

  // Build the byte stream, release reset, then drain and judge
  initial begin
    int         sel;
    int         waited;
    logic [3:0] nib;
    logic [7:0] st;

    // Data with no running status is dropped
    send(8'h00);
    // Note-on with a real-time byte between its data bytes, then running
    // status carrying a zero velocity that must come out as note-off
    send({NIB_NOTE_ON, 4'hF}); send(8'h3C); send(REALTIME_MIN); send(DATA_MAX);
    send(8'h3C); send(8'h00);
    send({NIB_NOTE_OFF, 4'h7}); send(DATA_MAX); send(DATA_MAX);
    send({NIB_POLY_TOUCH, 4'h5}); send(8'h01); send(8'h02);
    send({NIB_CONTROL, 4'h3}); send(8'h07); send(8'h64);
    // single data byte messages
    send({NIB_PROGRAM, 4'h9}); send(8'h05);
    send({NIB_CHAN_TOUCH, 4'hA}); send(8'h33);
    send({NIB_PITCH, 4'h0}); send(8'h00); send(8'h40);
    // SysEx with a real-time byte inside, closed by its stop byte
    send(STATUS_SX_START); send(8'h12); send(BYTE_MAX); send(STATUS_SX_STOP);
    // SysEx cut short by song position, whose two data bytes vanish and
    // leave no running status for the byte after them
    send(STATUS_SX_START); send(8'h55); send(STATUS_SONG_POS);
    send(8'h10); send(8'h20); send(8'h30);

    while (bytes_to_send.size() < RANDOM_BYTES + 30) begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        // channel voice status followed by a few messages in running status
        nib = 4'($urandom_range(NIB_NOTE_OFF, NIB_PITCH));
        st  = {nib, 4'($urandom_range(15))};
        send_live(st);
        repeat ($urandom_range(1, 4)) begin
          send_live(pick_data());
          if (nib != NIB_PROGRAM && nib != NIB_CHAN_TOUCH) begin
            if (nib == NIB_NOTE_ON && $urandom_range(3) == 0)
              send_live(8'h00);
            else
              send_live(pick_data());
          end
        end
      end else if (sel < 72) begin
        // SysEx, mostly closed properly, otherwise ended by another status
        send_live(STATUS_SX_START);
        repeat ($urandom_range(0, 6)) send_live(pick_data());
        if ($urandom_range(9) < 7)
          send_live(STATUS_SX_STOP);
        else
          send_live(8'($urandom_range({NIB_NOTE_OFF, 4'h0}, STATUS_SX_STOP - 1)));
      end else if (sel < 82) begin
        // system common status with too few, enough or extra data bytes
        send_live(8'($urandom_range(STATUS_SX_START + 1, STATUS_SX_STOP - 1)));
        repeat ($urandom_range(0, 3)) send_live(pick_data());
      end else if (sel < 90) begin
        send_live(8'($urandom_range(REALTIME_MIN, BYTE_MAX)));
      end else begin
        // raw noise
        repeat ($urandom_range(1, 3)) send(8'($urandom_range(BYTE_MAX)));
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Wait for the last byte to go across
    while (bytes_to_send.size() != 0 || rx_valid) @(posedge clk);

    // Drain owed events, then give stray ones a chance to show up
    waited = 0;
    while (events_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);

    if (events_due.size() != 0) begin
      $error("%0d expected events never arrived", events_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS midi_running_status_byte_parser");
    end else begin
      $display("FAIL midi_running_status_byte_parser");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #2_000_000;
    $display("FAIL midi_running_status_byte_parser");
    $finish;
  end

endmodule
